### src/ps2dt_pkg.sv
package ps2dt_pkg;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;

   localparam logic [4:0] START_LAST_PHASE  = 5'd1;
   localparam logic [4:0] DATA_LAST_PHASE   = 5'd17;
   localparam logic [4:0] PARITY_LAST_PHASE = 5'd19;
   localparam logic [4:0] STOP_LAST_PHASE   = 5'd21;
   localparam logic [4:0] LAST_PHASE        = 5'd26;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   localparam logic REG_HALF_PERIOD = 1'b0;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] head_byte;
      logic [7:0] queued_count;
   } queue_status_type;

   typedef struct packed {
      logic       push_dropped;
      logic [7:0] queued_count;
      logic       line_data;
      logic       line_clock;
   } rsp_payload_type;

   localparam int RSP_PAYLOAD_BITS = $bits(rsp_payload_type);

endpackage

### src/ps2dt_queue.sv
module ps2dt_queue #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ps2dt_pkg::queue_ctrl_type   ctrl,
   input  logic [7:0]                  push_byte,
   output ps2dt_pkg::queue_status_type status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   logic [7:0]    mem [QUEUE_DEPTH];
   logic [7:0]    head_byte_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] count_ff, count_in;
   logic [PW+7:0] count_ext;

   // The head entry is read every cycle. A push never writes the head slot while
   // the queue holds anything, and the first data bit is sent at least two beats
   // after a new head is set, so the registered read is always current in time.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_byte;
      end
      head_byte_ff <= mem[head_ff];
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign count_ext = {8'b0, count_in};

   assign status.empty        = (count_ff == '0);
   assign status.full         = (count_ff == LAST_SLOT);
   assign status.head_byte    = head_byte_ff;
   assign status.queued_count = count_ext[7:0];

endmodule

### src/ps2dt_rsp_buffer.sv
module ps2dt_rsp_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ps2dt_pkg::rsp_payload_type  in_payload,
   output logic                        out_valid,
   input  logic                        out_ready,
   output ps2dt_pkg::rsp_payload_type  out_payload
);

   ps2dt_pkg::rsp_payload_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       wr_fire;
   logic       rd_fire;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign wr_fire   = in_valid && in_ready;
   assign rd_fire   = out_valid && out_ready;
   assign out_payload = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         slot_ff[wr_ptr_ff] <= in_payload;
      end
   end

   always_comb begin
      wr_ptr_in = wr_fire ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_fire ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, wr_fire} - {1'b0, rd_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### src/ps2_device_byte_transmitter.sv
// PS/2 device-side transmitter. Bytes pushed on the request stream wait in a
// ring queue held in one memory of QUEUE_DEPTH bytes, which stores at most
// QUEUE_DEPTH-1 of them; a push to a full queue is dropped and flagged. Tick
// beats time the frame: every half_period_ticks ticks the transmitter takes one
// of 27 steps (start bit, eight data bits LSB first, odd parity, stop bit, an
// idle gap) and the last step removes the byte. The block takes one beat per
// clock cycle while its two-entry output buffer has room; each beat's result
// is registered in that buffer, so one stalled result does not hold up the
// next request beat. The rate is set by the tick and phase update and by the
// queue memory, whose head entry is read every cycle. The memory is not cleared
// after reset and needs no clearing pass.
module ps2_device_byte_transmitter #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // byte_value
   input  logic        req_tuser,    // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // line_clock, line_data, queued_count[7:0], push_dropped
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ps2dt_pkg::queue_ctrl_type   q_ctrl;
   ps2dt_pkg::queue_status_type q_status;
   ps2dt_pkg::rsp_payload_type  rsp_in_payload;
   ps2dt_pkg::rsp_payload_type  rsp_out_payload;

   logic [15:0] half_period_ff, half_period_in;
   logic [15:0] tick_ff, tick_in;
   logic [4:0]  phase_ff, phase_in;
   logic        clock_level_ff, clock_level_in;
   logic        data_level_ff, data_level_in;

   logic        req_fire;
   logic        is_push;
   logic        dropped;
   logic        tick_active;
   logic [16:0] tick_sum;
   logic        advance;
   logic [3:0]  bit_sel;
   logic        parity_bit;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ps2dt_pkg::REG_HALF_PERIOD) ?
                       {16'b0, half_period_ff} : 32'b0;

   always_comb begin
      half_period_in = half_period_ff;
      if (csr_write && csr_paddr[2] == ps2dt_pkg::REG_HALF_PERIOD) begin
         half_period_in = csr_pwdata[15:0];
      end
   end

   assign req_fire    = req_tvalid && req_tready;
   assign is_push     = (req_tuser == ps2dt_pkg::CMD_PUSH);
   assign dropped     = req_fire && is_push && q_status.full;
   assign tick_active = req_fire && !is_push && !q_status.empty;
   assign tick_sum    = {1'b0, tick_ff} + 17'd1;
   assign advance     = tick_active && (tick_sum >= {1'b0, half_period_ff});
   assign bit_sel     = phase_ff[4:1] - 4'd1;
   assign parity_bit  = ~(^q_status.head_byte);

   assign q_ctrl.push = req_fire && is_push && !q_status.full;
   assign q_ctrl.pop  = advance && (phase_ff >= ps2dt_pkg::LAST_PHASE);

   always_comb begin
      tick_in        = tick_ff;
      phase_in       = phase_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      if (tick_active) begin
         tick_in = tick_sum[15:0];
      end
      if (advance) begin
         tick_in  = 16'd0;
         phase_in = phase_ff + 5'd1;
         clock_level_in = phase_ff[0];
         priority if (phase_ff <= ps2dt_pkg::START_LAST_PHASE) begin
            data_level_in = 1'b0;
         end else if (phase_ff <= ps2dt_pkg::DATA_LAST_PHASE) begin
            data_level_in = q_status.head_byte[bit_sel[2:0]];
         end else if (phase_ff <= ps2dt_pkg::PARITY_LAST_PHASE) begin
            data_level_in = parity_bit;
         end else if (phase_ff <= ps2dt_pkg::STOP_LAST_PHASE) begin
            data_level_in = 1'b1;
         end else if (phase_ff < ps2dt_pkg::LAST_PHASE) begin
            clock_level_in = 1'b1;
            data_level_in  = 1'b1;
         end else begin
            clock_level_in = 1'b1;
            phase_in       = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= ps2dt_pkg::HALF_PERIOD_RESET;
         tick_ff        <= 16'd0;
         phase_ff       <= 5'd0;
         clock_level_ff <= 1'b1;
         data_level_ff  <= 1'b0;
      end else begin
         half_period_ff <= half_period_in;
         tick_ff        <= tick_in;
         phase_ff       <= phase_in;
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
      end
   end

   ps2dt_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_byte (req_tdata),
      .status    (q_status)
   );

   assign rsp_in_payload.push_dropped = dropped;
   assign rsp_in_payload.queued_count = q_status.queued_count;
   assign rsp_in_payload.line_data    = data_level_in;
   assign rsp_in_payload.line_clock   = clock_level_in;

   ps2dt_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_fire),
      .in_ready    (req_tready),
      .in_payload  (rsp_in_payload),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_payload (rsp_out_payload)
   );

   assign rsp_tdata = {(16 - ps2dt_pkg::RSP_PAYLOAD_BITS)'(0), rsp_out_payload};

endmodule

### src/ps2dt_checker.sv
module ps2dt_checker #(
   parameter int QUEUE_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   localparam logic [7:0] FULL_COUNT = 8'(QUEUE_DEPTH - 1);
   localparam logic       WIDE_QUEUE = (QUEUE_DEPTH > 256);

   // A beat left waiting must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // After every accepted request a result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");

   // A push is dropped only when the queue reports itself full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:2] == FULL_COUNT)
      else $error("push dropped with room in the queue");

   // The clock line is driven low only while a byte is being sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> WIDE_QUEUE || rsp_tdata[9:2] != 8'd0)
      else $error("clock line low with an empty queue");

endmodule

bind ps2_device_byte_transmitter ps2dt_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_ps2dt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/ps2_device_byte_transmitter_tb.sv
module ps2_device_byte_transmitter_tb;

   localparam int RING_SIZE = 256;

   class ps2_line_model;
      logic [7:0]                 ring [RING_SIZE];
      int unsigned                head;
      int unsigned                count;
      int unsigned                ticks;
      int unsigned                phase;
      logic                       clk_line;
      logic                       dat_line;
      logic [15:0]                half_period;
      ps2dt_pkg::rsp_payload_type pending_lines[$];
      int                         mismatch_count;

      function new();
         head = 0;
         count = 0;
         ticks = 0;
         phase = 0;
         clk_line = 1'b1;
         dat_line = 1'b0;
         half_period = ps2dt_pkg::HALF_PERIOD_RESET;
         mismatch_count = 0;
      endfunction

      function void step_frame();
         logic [7:0]  b;
         int unsigned ph;
         b = ring[head];
         ph = phase & 31;
         clk_line = ph[0];
         if (ph <= ps2dt_pkg::START_LAST_PHASE) begin
            dat_line = 1'b0;
         end else if (ph <= ps2dt_pkg::DATA_LAST_PHASE) begin
            dat_line = b[((ph >> 1) - 1) & 7];
         end else if (ph <= ps2dt_pkg::PARITY_LAST_PHASE) begin
            dat_line = ~^b;
         end else if (ph <= ps2dt_pkg::STOP_LAST_PHASE) begin
            dat_line = 1'b1;
         end else if (ph < ps2dt_pkg::LAST_PHASE) begin
            clk_line = 1'b1;
            dat_line = 1'b1;
         end else begin
            head = (head + 1) % RING_SIZE;
            if (count > 0) count--;
            clk_line = 1'b1;
            phase = 0;
            ticks = 0;
            return;
         end
         ticks = 0;
         phase = (ph + 1) & 31;
      endfunction

      function void take_beat(logic cmd, logic [7:0] value);
         ps2dt_pkg::rsp_payload_type r;
         r.push_dropped = 1'b0;
         if (cmd == ps2dt_pkg::CMD_PUSH) begin
            if (count >= RING_SIZE - 1) begin
               r.push_dropped = 1'b1;
            end else begin
               ring[(head + count) % RING_SIZE] = value;
               count++;
            end
         end else if (count != 0) begin
            ticks = (ticks + 1) & 'h1FFFF;
            if (ticks >= half_period) step_frame();
            ticks &= 'hFFFF;
         end
         r.line_clock = clk_line;
         r.line_data = dat_line;
         r.queued_count = count[7:0];
         pending_lines.push_back(r);
      endfunction

      function void check_beat(logic [15:0] data);
         ps2dt_pkg::rsp_payload_type want;
         ps2dt_pkg::rsp_payload_type got;
         if (pending_lines.size() == 0) begin
            $error("unexpected result beat %h", data);
            mismatch_count++;
            return;
         end
         want = pending_lines.pop_front();
         got = data[ps2dt_pkg::RSP_PAYLOAD_BITS-1:0];
         if (got.line_clock !== want.line_clock) begin
            $error("line_clock: expected %0d, actual %0d", want.line_clock, got.line_clock);
            mismatch_count++;
         end
         if (got.line_data !== want.line_data) begin
            $error("line_data: expected %0d, actual %0d", want.line_data, got.line_data);
            mismatch_count++;
         end
         if (got.queued_count !== want.queued_count) begin
            $error("queued_count: expected %0d, actual %0d", want.queued_count,
                   got.queued_count);
            mismatch_count++;
         end
         if (got.push_dropped !== want.push_dropped) begin
            $error("push_dropped: expected %0d, actual %0d", want.push_dropped,
                   got.push_dropped);
            mismatch_count++;
         end
         if (data[15:ps2dt_pkg::RSP_PAYLOAD_BITS] !== '0) begin
            $error("padding: expected 0, actual %h", data[15:ps2dt_pkg::RSP_PAYLOAD_BITS]);
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // byte_value
   logic        req_tuser = 1'b0;  // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // line_clock, line_data, queued_count[7:0], push_dropped
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ps2_line_model lines;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_orders = 0;
   int hold_served = 0;
   int hold_left = 0;

   ps2_device_byte_transmitter #(.QUEUE_DEPTH(RING_SIZE)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_served != hold_orders) begin
         hold_served <= hold_orders;
         hold_left <= 80;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) lines.take_beat(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) lines.check_beat(rsp_tdata);
      end
   end

   task automatic send_beat(logic cmd, logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_mixed(int n, int push_pct);
      repeat (n) begin
         if ($urandom_range(99) < push_pct) begin
            send_beat(ps2dt_pkg::CMD_PUSH, 8'($urandom_range(255)));
         end else begin
            send_beat(ps2dt_pkg::CMD_TICK, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lines.pending_lines.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_half_period(logic [15:0] value);
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {ps2dt_pkg::REG_HALF_PERIOD, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      lines.half_period = value;
   endtask

   task automatic set_pacing(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
   endtask

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      lines = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_pacing(0, 0);
      send_beat(ps2dt_pkg::CMD_TICK, 8'h00);
      send_beat(ps2dt_pkg::CMD_TICK, 8'hFF);
      send_beat(ps2dt_pkg::CMD_PUSH, 8'h00);
      repeat (3) send_beat(ps2dt_pkg::CMD_TICK, 8'h00);
      // The counter now stands above the new half period.
      set_half_period(16'd1);
      send_beat(ps2dt_pkg::CMD_TICK, 8'h00);
      send_beat(ps2dt_pkg::CMD_PUSH, 8'hFF);
      send_beat(ps2dt_pkg::CMD_PUSH, 8'hA5);
      repeat (15) send_beat(ps2dt_pkg::CMD_TICK, 8'h00);

      set_half_period(16'd0);
      send_mixed(40, 12);

      set_half_period(16'd1);
      set_pacing(52, 0);
      send_mixed(50, 15);

      set_half_period(16'd2);
      set_pacing(0, 52);
      send_mixed(50, 15);

      set_half_period(16'($urandom_range(1, 5)));
      set_pacing(9, 9);
      send_mixed(50, 15);

      // The receiver holds off while the sender keeps offering beats.
      set_half_period(16'd1);
      set_pacing(0, 0);
      hold_orders <= hold_orders + 1;
      send_mixed(30, 20);

      // Fill the queue past its capacity so that pushes are dropped.
      set_half_period(16'd3);
      set_pacing(9, 9);
      repeat (262) send_beat(ps2dt_pkg::CMD_PUSH, 8'($urandom_range(255)));
      send_mixed(30, 30);

      set_half_period(16'hFFFF);
      set_pacing(0, 0);
      send_mixed(15, 20);

      drain_results();
      repeat (10) @(posedge clock);
      if (lines.mismatch_count == 0 && lines.pending_lines.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
src/ps2dt_pkg.sv
src/ps2dt_queue.sv
src/ps2dt_rsp_buffer.sv
src/ps2_device_byte_transmitter.sv
src/ps2dt_checker.sv
tb/sv/ps2_device_byte_transmitter_tb.sv
